/* hdl/dusk_light_switch_controller_defines.svh */
// ----------------------------------------------------------------------------
// Dusk light switch controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DUSK_LIGHT_SWITCH_CONTROLLER_DEFINES_SVH
`define DUSK_LIGHT_SWITCH_CONTROLLER_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define DLSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define DLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/dlsc_pkg.sv */
// ----------------------------------------------------------------------------
// Dusk light switch controller package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package dlsc_pkg;

  localparam int MAX_HOURS    = 8;
  localparam int SEC_PER_HOUR = 3600;

  localparam logic [14:0] COUNT_MAX         = 15'd32767;
  localparam logic [9:0]  BRIGHT_THR_RST    = 10'd350;
  localparam logic [9:0]  HYSTERESIS_RST    = 10'd10;
  localparam logic [7:0]  TICK_SECONDS_RST  = 8'd4;
  localparam logic [9:0]  DARK_THR_RST      = 10'd700;
  localparam logic [3:0]  ON_HOURS_RST      = 4'd2;

  localparam logic [1:0] CFG_IDX_BRIGHT_THR   = 2'd0;
  localparam logic [1:0] CFG_IDX_HYSTERESIS   = 2'd1;
  localparam logic [1:0] CFG_IDX_TICK_SECONDS = 2'd2;

  localparam logic [1:0] MODE_CODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_CODE_ON   = 2'd1;
  localparam logic [1:0] MODE_CODE_WAIT = 2'd2;

  typedef enum logic [2:0] {
    MODE_OFF  = 3'b001,
    MODE_ON   = 3'b010,
    MODE_WAIT = 3'b100
  } mode_t;

  typedef struct packed {
    logic [9:0] bright_thr;
    logic [9:0] hysteresis;
    logic [7:0] tick_seconds;
  } cfg_t;

  typedef struct packed {
    logic [9:0] light_level;
    logic       button_pressed;
    logic [7:0] hold_steps;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic [14:0] countdown;
    logic [9:0]  dark_thr;
    logic [3:0]  hours;
  } state_t;

  function automatic logic [14:0] load_value(input logic [3:0] hours);
    logic [16:0] prod;
    prod = 17'(hours) * 17'(SEC_PER_HOUR);
    if (prod > 17'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return prod[14:0];
  endfunction

  function automatic logic [1:0] mode_code(input mode_t mode);
    logic [1:0] code;
    unique case (mode)
      MODE_OFF:  code = MODE_CODE_OFF;
      MODE_ON:   code = MODE_CODE_ON;
      MODE_WAIT: code = MODE_CODE_WAIT;
      default:   code = MODE_CODE_OFF;
    endcase
    return code;
  endfunction

endpackage

/* hdl/dlsc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Dusk light switch controller configuration registers
// Holds the brightness threshold, hysteresis and tick length.
// ----------------------------------------------------------------------------
module dlsc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [9:0]    cfg_wdata,
  output dlsc_pkg::cfg_t cfg
);

  dlsc_pkg::cfg_t cfg_r;
  dlsc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dlsc_pkg::CFG_IDX_BRIGHT_THR:   cfg_nxt.bright_thr   = cfg_wdata;
        dlsc_pkg::CFG_IDX_HYSTERESIS:   cfg_nxt.hysteresis   = cfg_wdata;
        dlsc_pkg::CFG_IDX_TICK_SECONDS: cfg_nxt.tick_seconds = cfg_wdata[7:0];
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bright_thr   <= dlsc_pkg::BRIGHT_THR_RST;
      cfg_r.hysteresis   <= dlsc_pkg::HYSTERESIS_RST;
      cfg_r.tick_seconds <= dlsc_pkg::TICK_SECONDS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/dlsc_step.sv */
// ----------------------------------------------------------------------------
// Dusk light switch controller step logic
// Computes the next controller state from one tick and the current state.
// ----------------------------------------------------------------------------
module dlsc_step (
  input  dlsc_pkg::cfg_t   cfg,
  input  dlsc_pkg::item_t  item,
  input  dlsc_pkg::state_t cur,
  output dlsc_pkg::state_t nxt
);

  logic [14:0]        load_cur;
  logic [14:0]        load_new;
  logic [3:0]         hold_sel;
  logic signed [11:0] off_level;
  logic               level_below;
  dlsc_pkg::mode_t    mode_a;
  logic [14:0]        cnt_a;
  logic [9:0]         dark_a;
  logic [3:0]         hours_a;
  logic [14:0]        cnt_b;
  dlsc_pkg::mode_t    mode_b;

  assign load_cur  = dlsc_pkg::load_value(cur.hours);
  assign hold_sel  = 4'(((32'(item.hold_steps) - 32'd1) % dlsc_pkg::MAX_HOURS) + 32'd1);

  // Button handling.
  always_comb begin
    mode_a  = cur.mode;
    cnt_a   = cur.countdown;
    dark_a  = cur.dark_thr;
    hours_a = cur.hours;
    if (item.button_pressed) begin
      if (cur.mode == dlsc_pkg::MODE_ON) begin
        mode_a = dlsc_pkg::MODE_WAIT;
      end else begin
        mode_a = dlsc_pkg::MODE_ON;
        cnt_a  = load_cur;
        dark_a = item.light_level;
      end
      if (item.hold_steps != 8'd0) begin
        hours_a = hold_sel;
      end
    end
  end

  assign load_new    = dlsc_pkg::load_value(hours_a);
  assign off_level   = $signed({2'b00, dark_a}) - $signed({2'b00, cfg.hysteresis});
  assign level_below = $signed({2'b00, item.light_level}) < off_level;

  // Light transitions and countdown.
  always_comb begin
    mode_b = mode_a;
    cnt_b  = cnt_a;
    if (mode_b == dlsc_pkg::MODE_WAIT && item.light_level <= cfg.bright_thr) begin
      mode_b = dlsc_pkg::MODE_OFF;
    end
    if (mode_b == dlsc_pkg::MODE_OFF && item.light_level >= dark_a) begin
      cnt_b  = load_new;
      mode_b = dlsc_pkg::MODE_ON;
    end else if (mode_b == dlsc_pkg::MODE_ON && cnt_a == 15'd0) begin
      mode_b = dlsc_pkg::MODE_WAIT;
    end else if (mode_b == dlsc_pkg::MODE_ON && level_below) begin
      mode_b = dlsc_pkg::MODE_OFF;
    end
    if (cnt_b > 15'(cfg.tick_seconds)) begin
      cnt_b = cnt_b - 15'(cfg.tick_seconds);
    end else begin
      cnt_b = 15'd0;
    end
  end

  always_comb begin
    nxt.mode      = mode_b;
    nxt.countdown = cnt_b;
    nxt.dark_thr  = dark_a;
    nxt.hours     = hours_a;
  end

endmodule

/* hdl/dusk_light_switch_controller.sv */
// ----------------------------------------------------------------------------
// Dusk light switch controller
// Dusk-to-dawn lamp switch with button, learned dark threshold and on-timer.
// ----------------------------------------------------------------------------
// Each input beat is one wake tick: a light sample and hold count on in_tdata
// and the button flag on in_tuser. Each tick yields exactly one output beat
// with the lamp drive, mode, remaining seconds, dark threshold and duration.
// A beat accepted on the input is held in the input register until it advances;
// then the step logic processes it and its result goes into the output register
// and is shown on out_tvalid. One beat can be taken in every cycle while the
// receiver keeps out_tready high; the controller state updates once per advance.
// Reset clears both pipeline stages and returns the controller to off with
// zero countdown, dark threshold 700, two hours of duration, and the
// configuration registers to their defaults. The configuration port writes
// one register per cycle and must only be used while no tick is in flight.
// When the receiver holds out_tready low, the output register keeps its beat,
// the input register still takes one more beat, and in_tready then drops
// until the output frees up.
// ----------------------------------------------------------------------------
`include "dusk_light_switch_controller_defines.svh"

module dusk_light_switch_controller (
  input  logic        clk,
  input  logic        rst_n,
  // light_level [9:0], hold_steps [17:10], zero fill [23:18]
  input  logic [23:0] in_tdata,
  // button_pressed [0]
  input  logic [0:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // load_on [0], mode [2:1], remaining_seconds [17:3],
  // learned_dark_threshold [27:18], duration_hours [31:28]
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);

  dlsc_pkg::cfg_t   cfg;
  dlsc_pkg::item_t  item_r;
  dlsc_pkg::state_t st_r;
  dlsc_pkg::state_t st_nxt;
  logic             in_valid_r;
  logic             out_valid_r;
  logic [31:0]      out_data_r;
  logic             advance;
  logic             in_take;

  dlsc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  dlsc_step u_step (
    .cfg (cfg),
    .item(item_r),
    .cur (st_r),
    .nxt (st_nxt)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.light_level    <= in_tdata[9:0];
      item_r.hold_steps     <= in_tdata[17:10];
      item_r.button_pressed <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode      <= dlsc_pkg::MODE_OFF;
      st_r.countdown <= 15'd0;
      st_r.dark_thr  <= dlsc_pkg::DARK_THR_RST;
      st_r.hours     <= dlsc_pkg::ON_HOURS_RST;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {st_nxt.hours, st_nxt.dark_thr, st_nxt.countdown,
                     dlsc_pkg::mode_code(st_nxt.mode),
                     (st_nxt.mode == dlsc_pkg::MODE_ON)};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  `DLSC_ASSERT_ALWAYS(a_hours_range, (st_r.hours >= 4'd1) && (st_r.hours <= 4'(dlsc_pkg::MAX_HOURS)), "duration out of range")
  `DLSC_ASSERT_NEXT(a_stage_hold, (in_valid_r && !advance), (in_valid_r && $stable(item_r)), "pending tick lost")
  `DLSC_ASSERT_NEXT(a_state_idle, (!advance), ($stable(st_r)), "state changed without a tick")

endmodule

/* verif/dlsc_checker.sv */
// ----------------------------------------------------------------------------
// Dusk light switch controller checker
// Watches the tick and result streams and the configuration port, keeps its
// own copy of the lamp controller state, predicts the result beat of every
// accepted tick and compares it field by field with the beats that come out.
// ----------------------------------------------------------------------------
module dlsc_checker (
  input  logic        clk,
  input  logic        rst_n,
  // light_level [9:0], hold_steps [17:10], zero fill [23:18]
  input  logic [23:0] in_tdata,
  // button_pressed [0]
  input  logic [0:0]  in_tuser,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // load_on [0], mode [2:1], remaining_seconds [17:3],
  // learned_dark_threshold [27:18], duration_hours [31:28]
  input  logic [31:0] out_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [3:0]  hours;
    logic [9:0]  dark;
    logic [14:0] remaining;
    logic [1:0]  mode;
    logic        load_on;
  } lamp_result_t;

  logic [9:0]  bright_thr_q;
  logic [9:0]  hyst_q;
  logic [7:0]  tick_q;
  logic [1:0]  mode_q;
  logic [14:0] count_q;
  logic [9:0]  dark_q;
  logic [3:0]  hours_q;

  lamp_result_t lamp_due_q[$];
  lamp_result_t seen;
  lamp_result_t due;
  int           errors = 0;

  function automatic logic [14:0] full_count(input logic [3:0] hours);
    int secs;
    secs = int'(hours) * dlsc_pkg::SEC_PER_HOUR;
    return (secs > int'(dlsc_pkg::COUNT_MAX)) ? dlsc_pkg::COUNT_MAX : 15'(secs);
  endfunction

  task automatic step_lamp(input dlsc_pkg::item_t tick, output lamp_result_t res);
    int off_level;
    if (tick.button_pressed) begin
      if (mode_q == dlsc_pkg::MODE_CODE_ON) begin
        mode_q = dlsc_pkg::MODE_CODE_WAIT;
      end else begin
        mode_q  = dlsc_pkg::MODE_CODE_ON;
        count_q = full_count(hours_q);
        dark_q  = tick.light_level;
      end
      if (tick.hold_steps != 8'd0) begin
        hours_q = 4'((int'(tick.hold_steps) - 1) % dlsc_pkg::MAX_HOURS + 1);
      end
    end
    if (mode_q == dlsc_pkg::MODE_CODE_WAIT && tick.light_level <= bright_thr_q) begin
      mode_q = dlsc_pkg::MODE_CODE_OFF;
    end
    // The off level is signed, so a margin above the threshold never fires.
    off_level = int'(dark_q) - int'(hyst_q);
    if (mode_q == dlsc_pkg::MODE_CODE_OFF && tick.light_level >= dark_q) begin
      count_q = full_count(hours_q);
      mode_q  = dlsc_pkg::MODE_CODE_ON;
    end else if (mode_q == dlsc_pkg::MODE_CODE_ON && count_q == 15'd0) begin
      mode_q = dlsc_pkg::MODE_CODE_WAIT;
    end else if (mode_q == dlsc_pkg::MODE_CODE_ON && int'(tick.light_level) < off_level) begin
      mode_q = dlsc_pkg::MODE_CODE_OFF;
    end
    if (count_q != 15'd0) begin
      count_q = (count_q > 15'(tick_q)) ? count_q - 15'(tick_q) : 15'd0;
    end
    res.load_on   = (mode_q == dlsc_pkg::MODE_CODE_ON);
    res.mode      = mode_q;
    res.remaining = count_q;
    res.dark      = dark_q;
    res.hours     = hours_q;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bright_thr_q = dlsc_pkg::BRIGHT_THR_RST;
      hyst_q       = dlsc_pkg::HYSTERESIS_RST;
      tick_q       = dlsc_pkg::TICK_SECONDS_RST;
      mode_q       = dlsc_pkg::MODE_CODE_OFF;
      count_q      = 15'd0;
      dark_q       = dlsc_pkg::DARK_THR_RST;
      hours_q      = dlsc_pkg::ON_HOURS_RST;
      lamp_due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dlsc_pkg::CFG_IDX_BRIGHT_THR:   bright_thr_q = cfg_wdata;
          dlsc_pkg::CFG_IDX_HYSTERESIS:   hyst_q = cfg_wdata;
          dlsc_pkg::CFG_IDX_TICK_SECONDS: tick_q = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        seen = lamp_result_t'(out_tdata);
        if (lamp_due_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("Unexpected result beat %h with no tick outstanding.", out_tdata);
          end
        end else begin
          due = lamp_due_q.pop_front();
          if (seen.load_on !== due.load_on || seen.mode !== due.mode ||
              seen.remaining !== due.remaining || seen.dark !== due.dark ||
              seen.hours !== due.hours) begin
            errors++;
            if (errors <= 10) begin
              $display("Mismatch: expected load_on=%0d mode=%0d remaining=%0d dark=%0d hours=%0d",
                       due.load_on, due.mode, due.remaining, due.dark, due.hours);
              $display("          actual   load_on=%0d mode=%0d remaining=%0d dark=%0d hours=%0d",
                       seen.load_on, seen.mode, seen.remaining, seen.dark, seen.hours);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        step_lamp(dlsc_pkg::item_t'({in_tdata[9:0], in_tuser[0], in_tdata[17:10]}), due);
        lamp_due_q.push_back(due);
      end
    end
    mismatches  <= errors;
    outstanding <= lamp_due_q.size();
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Dusk light switch controller testbench
// Drives a directed opening of wake ticks and then phases of random tick runs
// (dark, bright, near-threshold and noisy) under several register settings,
// with random idling on both streams, a long receiver hold-off and a drain
// between phases. The checker beside the block predicts every result beat.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TICKS_PER_PHASE = 275;
  localparam int NUM_PHASES      = 6;
  localparam int QUIET_LIMIT     = 3000;
  localparam int HOLDOFF_CYCLES  = 80;
  localparam int HOLDOFF_AFTER   = 600;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [9:0]  cfg_wdata  = '0;

  int mismatches;
  int outstanding;
  int ticks_sent   = 0;
  int quiet_cycles = 0;
  bit steady       = 1'b0;
  bit holdoff_done = 1'b0;

  int bright_now = dlsc_pkg::BRIGHT_THR_RST;
  int hyst_now   = dlsc_pkg::HYSTERESIS_RST;
  int dark_guess = dlsc_pkg::DARK_THR_RST;
  int run_kind   = 0;
  int run_left   = 0;
  int edge_pick  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dusk_light_switch_controller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  dlsc_checker u_lamp_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Result side: random back-pressure and one long hold-off while ticks keep coming.
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!holdoff_done && ticks_sent >= HOLDOFF_AFTER) begin
        holdoff_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      out_tready <= steady || ($urandom_range(99) >= 23);
    end
  end

  task automatic send_tick(input int level, input bit pressed, input int hold);
    while (!steady && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {6'd0, 8'(hold), 10'(level)};
    in_tuser  <= pressed;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ticks_sent++;
    if (pressed) begin
      dark_guess = level;
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 10'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input int bright, input int hyst, input int tick);
    write_reg(dlsc_pkg::CFG_IDX_BRIGHT_THR, bright);
    write_reg(dlsc_pkg::CFG_IDX_HYSTERESIS, hyst);
    write_reg(dlsc_pkg::CFG_IDX_TICK_SECONDS, tick);
    bright_now = bright;
    hyst_now   = hyst;
  endtask

  task automatic send_random_tick();
    int level;
    int center;
    int hold;
    bit pressed;
    if (run_left == 0) begin
      run_kind = $urandom_range(3);
      run_left = $urandom_range(40, 4);
    end
    run_left--;
    case (run_kind)
      0: begin
        level = $urandom_range(1023);
      end
      1: begin
        level = dark_guess + $urandom_range(1023 - dark_guess);
      end
      2: begin
        level = $urandom_range(bright_now);
      end
      default: begin
        edge_pick = (edge_pick + 1) % 3;
        center = (edge_pick == 0) ? dark_guess :
                 (edge_pick == 1) ? dark_guess - hyst_now : bright_now;
        level = center + $urandom_range(24) - 12;
        if (level < 0) begin
          level = 0;
        end
        if (level > 1023) begin
          level = 1023;
        end
      end
    endcase
    pressed = ($urandom_range(99) < ((run_kind == 1) ? 3 : 10));
    case ($urandom_range(3))
      0:       hold = 0;
      1:       hold = $urandom_range(16, 1);
      default: hold = $urandom_range(255);
    endcase
    send_tick(level, pressed, hold);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening ticks at the reset settings.
    send_tick(0, 1'b0, 0);
    send_tick(0, 1'b0, 255);
    send_tick(1023, 1'b0, 0);
    send_tick(1023, 1'b1, 0);
    send_tick(500, 1'b0, 0);
    send_tick(350, 1'b0, 0);
    send_tick(3, 1'b1, 1);
    send_tick(0, 1'b0, 0);
    send_tick(3, 1'b1, 8);
    send_tick(1023, 1'b1, 9);
    send_tick(0, 1'b1, 255);
    send_tick(0, 1'b0, 16);
    send_tick(1023, 1'b1, 0);
    send_tick(0, 1'b0, 0);
    send_tick(1023, 1'b1, 128);
    send_tick(351, 1'b0, 170);
    send_tick(689, 1'b0, 0);
    send_tick(512, 1'b1, 85);
    send_tick(520, 1'b0, 0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       set_thresholds(350, 10, 255);
        1:       set_thresholds(0, 0, 1);
        2:       set_thresholds(1023, 1023, 0);
        3:       set_thresholds($urandom_range(1023), $urandom_range(63), 255);
        4:       set_thresholds($urandom_range(1023), $urandom_range(1023),
                                $urandom_range(255, 1));
        default: set_thresholds(512, 40, 128);
      endcase
      steady = (phase == 1);
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        send_random_tick();
      end
    end

    steady = 1'b0;
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/dlsc_pkg.sv
hdl/dlsc_cfg_regs.sv
hdl/dlsc_step.sv
hdl/dusk_light_switch_controller.sv
verif/dlsc_checker.sv
verif/tb_top.sv
